[hw/rtl/swhsd_pkg.sv]
// Package with the shared types and constants of the single-wire humidity sensor decoder.
`default_nettype none

package swhsd_pkg;

    // Fixed frame geometry of the sensor protocol.
    localparam int FRAME_BYTES = 5;
    localparam int FRAME_BITS  = 40;
    localparam int BIT_MAX     = 63;
    localparam int RUN_MAX     = 255;

    // Level changes that precede the first data bit (response preamble).
    localparam int SKIP_EDGES  = 4;

    // Configuration port.
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_BIT_THRESHOLD = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_TICKS = 8'd1;

    localparam logic [7:0] BIT_THRESHOLD_RST = 8'd16;
    localparam logic [7:0] TIMEOUT_TICKS_RST = 8'd255;

    // One pin sample.
    typedef struct packed {
        logic start_req;
        logic pin_level;
    } t_in;

    // One decoded measurement.
    typedef struct packed {
        logic [15:0]        humidity_tenths;
        logic signed [15:0] temperature_tenths;
        logic [5:0]         bits_received;
        logic               checksum_ok;
        logic               frame_valid;
    } t_out;

    // Register values seen by the capture logic.
    typedef struct packed {
        logic [7:0] bit_threshold;
        logic [7:0] timeout_ticks;
    } t_cfg;

    // Captured frame handed to the result stage.
    typedef struct packed {
        logic [FRAME_BYTES-1:0][7:0] bytes;
        logic [5:0]                  bit_index;
    } t_frame;

    // Status of the capture logic for the current sample.
    typedef struct packed {
        logic emit;
        logic capturing;
    } t_cap_status;

endpackage

`default_nettype wire

[hw/rtl/swhsd_capture.sv]
// Capture state machine: run counting, edge numbering and bit shifting into the frame.
`default_nettype none

module swhsd_capture #(
    parameter int EDGE_LIMIT = 100
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_step,
    input  swhsd_pkg::t_in       i_item,
    input  swhsd_pkg::t_cfg      i_cfg,
    output swhsd_pkg::t_frame    o_frame,
    output swhsd_pkg::t_cap_status o_status
);
    import swhsd_pkg::*;

    localparam int EDGE_W = $clog2(EDGE_LIMIT + 1);

    logic                        r_capturing, n_capturing;
    logic                        r_last_level, n_last_level;
    logic [7:0]                  r_run_ticks, n_run_ticks;
    logic [EDGE_W-1:0]           r_edge_index, n_edge_index;
    logic [5:0]                  r_bit_index, n_bit_index;
    logic [FRAME_BYTES-1:0][7:0] r_bytes, n_bytes;
    logic                        n_emit;

    // Next state for the sample in the input register.
    always_comb begin
        logic                        cap;
        logic                        last;
        logic [7:0]                  run;
        logic [EDGE_W-1:0]           edg;
        logic [5:0]                  bidx;
        logic [FRAME_BYTES-1:0][7:0] bytes;

        // A start request begins a fresh capture with this very sample.
        if (i_item.start_req) begin
            cap   = 1'b1;
            last  = 1'b1;
            run   = '0;
            edg   = '0;
            bidx  = '0;
            bytes = '0;
        end else begin
            cap   = r_capturing;
            last  = r_last_level;
            run   = r_run_ticks;
            edg   = r_edge_index;
            bidx  = r_bit_index;
            bytes = r_bytes;
        end

        n_capturing  = cap;
        n_last_level = last;
        n_run_ticks  = run;
        n_edge_index = edg;
        n_bit_index  = bidx;
        n_bytes      = bytes;
        n_emit       = 1'b0;

        if (cap) begin
            if (i_item.pin_level == last) begin
                // Unchanged level: extend the run and check for timeout.
                if (run != 8'(RUN_MAX)) begin
                    n_run_ticks = run + 8'd1;
                end
                if (n_run_ticks >= i_cfg.timeout_ticks) begin
                    n_emit      = 1'b1;
                    n_capturing = 1'b0;
                end
            end else begin
                // Level change: every even change past the preamble ends a data bit.
                n_last_level = i_item.pin_level;
                if (edg >= EDGE_W'(SKIP_EDGES) && !edg[0]) begin
                    if (bidx < 6'(FRAME_BITS)) begin
                        n_bytes[bidx[5:3]] = {bytes[bidx[5:3]][6:0],
                                              (run > i_cfg.bit_threshold)};
                    end
                    if (bidx != 6'(BIT_MAX)) begin
                        n_bit_index = bidx + 6'd1;
                    end
                end
                n_run_ticks  = '0;
                n_edge_index = edg + EDGE_W'(1);
                if (n_edge_index >= EDGE_W'(EDGE_LIMIT)) begin
                    n_emit      = 1'b1;
                    n_capturing = 1'b0;
                end
            end
        end
    end

    // State registers advance only when a sample is processed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capturing  <= 1'b0;
            r_last_level <= 1'b1;
            r_run_ticks  <= '0;
            r_edge_index <= '0;
            r_bit_index  <= '0;
            r_bytes      <= '0;
        end else if (i_step) begin
            r_capturing  <= n_capturing;
            r_last_level <= n_last_level;
            r_run_ticks  <= n_run_ticks;
            r_edge_index <= n_edge_index;
            r_bit_index  <= n_bit_index;
            r_bytes      <= n_bytes;
        end
    end

    // The frame as it stands after this sample.
    assign o_frame.bytes      = n_bytes;
    assign o_frame.bit_index  = n_bit_index;
    assign o_status.emit      = n_emit;
    assign o_status.capturing = r_capturing;

endmodule

`default_nettype wire

[hw/rtl/swhsd_result.sv]
// Result formatting and output register with valid/ready handshake.
`default_nettype none

module swhsd_result (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_load,
    input  swhsd_pkg::t_frame  i_frame,
    output logic               o_free,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output swhsd_pkg::t_out    o_out_data
);
    import swhsd_pkg::*;

    logic        r_valid;
    t_out        r_data, n_data;
    logic [14:0] w_mag;
    logic [7:0]  w_sum;

    // Decode the five frame bytes into the measurement fields.
    always_comb begin
        w_mag = {i_frame.bytes[2][6:0], i_frame.bytes[3]};
        w_sum = i_frame.bytes[0] + i_frame.bytes[1] + i_frame.bytes[2] + i_frame.bytes[3];
        n_data.humidity_tenths = {i_frame.bytes[0], i_frame.bytes[1]};
        // Sign-magnitude to two's complement; negative zero becomes zero.
        if (i_frame.bytes[2][7]) begin
            n_data.temperature_tenths = -$signed({1'b0, w_mag});
        end else begin
            n_data.temperature_tenths = $signed({1'b0, w_mag});
        end
        n_data.bits_received = i_frame.bit_index;
        n_data.checksum_ok   = (i_frame.bytes[4] == w_sum);
        n_data.frame_valid   = (i_frame.bit_index >= 6'(FRAME_BITS)) && n_data.checksum_ok;
    end

    // The slot is free when empty or being emptied in this cycle.
    assign o_free = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_data <= n_data;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

`default_nettype wire

[hw/rtl/single_wire_humidity_sensor_decoder_top.sv]
// Top level of the single-wire humidity sensor decoder.
`default_nettype none

// Decodes the single-wire response of a humidity and temperature sensor from
// pin samples, one sample per transaction. The block accepts one sample every
// clock cycle while its result slot is free; a sample passes an input register,
// then the capture logic, whose state update is the loop that sets the
// one-sample-per-cycle rate, and its result, if any, enters the output
// register as the sample moves on. A capture starts with a sample that
// carries start_req and ends, with one result transaction, when a level run
// reaches timeout_ticks or when EDGE_LIMIT level changes have been seen.
// Registers 0 (bit_threshold) and 1 (timeout_ticks) may be written only while
// no capture is in progress and no result is pending.
module single_wire_humidity_sensor_decoder_top #(
    parameter int EDGE_LIMIT = 100
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  swhsd_pkg::t_in                      i_in_data,
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output swhsd_pkg::t_out                     o_out_data,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire [swhsd_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  wire [swhsd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import swhsd_pkg::*;

    logic        r_in_valid;
    t_in         r_in;
    logic        w_free;
    logic        w_step;
    logic [7:0]  r_bit_threshold;
    logic [7:0]  r_timeout_ticks;
    t_cfg        w_cfg;
    t_frame      w_frame;
    t_cap_status w_status;

    // Input register: refilled whenever it is empty or its sample moves on.
    assign w_step     = r_in_valid && w_free;
    assign o_in_ready = !r_in_valid || w_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // Configuration registers, always ready for a write.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_threshold <= BIT_THRESHOLD_RST;
            r_timeout_ticks <= TIMEOUT_TICKS_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_BIT_THRESHOLD: r_bit_threshold <= i_cfg_data;
                REG_TIMEOUT_TICKS: r_timeout_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_cfg.bit_threshold = r_bit_threshold;
    assign w_cfg.timeout_ticks = r_timeout_ticks;

    // Capture logic.
    swhsd_capture #(
        .EDGE_LIMIT (EDGE_LIMIT)
    ) u_capture (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_item   (r_in),
        .i_cfg    (w_cfg),
        .o_frame  (w_frame),
        .o_status (w_status)
    );

    // Result formatting and output register.
    swhsd_result u_result (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_step && w_status.emit),
        .i_frame     (w_frame),
        .o_free      (w_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // A finished capture always shows up as a result in the next cycle.
    a_emit_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_status.emit) |=> o_out_valid)
        else $error("finished capture gave no result");

    // A result comes only from a running capture or one started by this sample.
    a_emit_needs_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_status.emit) |-> (w_status.capturing || r_in.start_req))
        else $error("result without a capture");

    // A capture that produced its result is no longer running.
    a_emit_ends_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_status.emit) |=> !w_status.capturing)
        else $error("capture still running after its result");

endmodule

`default_nettype wire

[tb/single_wire_humidity_sensor_decoder_top_tb.sv]
// Self-checking testbench for the single-wire humidity sensor decoder top level.
`timescale 1ns / 100ps

module single_wire_humidity_sensor_decoder_top_tb;
    import swhsd_pkg::*;

    localparam int HALF_PERIOD    = 6;
    localparam int EDGE_LIMIT     = 100;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEM_GOAL      = 1650;
    localparam int READING_GOAL   = 40;
    localparam int PHASE_ITEMS    = 80;

    // Register settings per phase, phase 0 in the lowest byte.
    localparam logic [7:0][7:0] PHASE_THR =
        {8'd0, 8'd3, 8'd0, 8'd1, 8'd255, 8'd2, 8'd0, 8'd1};
    localparam logic [7:0][7:0] PHASE_TMO =
        {8'd1, 8'd12, 8'd4, 8'd255, 8'd255, 8'd9, 8'd3, 8'd6};

    // An empty frame: no bits, all bytes zero, so the checksum matches.
    localparam t_out BLANK_READING = {16'd0, 16'd0, 6'd0, 1'b1, 1'b0};

    typedef enum logic [1:0] {
        END_BY_TIMEOUT,
        END_AT_LIMIT,
        END_ABORTED
    } t_frame_end;

    typedef struct packed {
        logic                   is_cfg;
        logic [CFG_INDEX_W-1:0] idx;
        logic [CFG_DATA_W-1:0]  val;
        t_in                    smp;
        logic                   typed;
        t_out                   want;
    } t_directed_row;

    // Block ports.
    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    t_in                    i_in_data = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    t_out                   o_out_data;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    // Decoder state as predicted by the testbench.
    logic [7:0]                  thr_reg = BIT_THRESHOLD_RST;
    logic [7:0]                  tmo_reg = TIMEOUT_TICKS_RST;
    logic                        cap_on = 1'b0;
    logic                        prev_lvl = 1'b1;
    logic [7:0]                  run_cnt = '0;
    logic [7:0]                  edge_cnt = '0;
    logic [5:0]                  bit_cnt = '0;
    logic [FRAME_BYTES-1:0][7:0] frm = '0;

    t_out          pending_readings [$];
    t_directed_row directed_steps [$];

    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    int hold_grants   = 0;
    int holds_served  = 0;
    int hold_left     = 0;
    int items_sent    = 0;
    int readings_seen = 0;
    int mismatches    = 0;
    int quiet_cycles  = 0;

    single_wire_humidity_sensor_decoder_top #(
        .EDGE_LIMIT(EDGE_LIMIT)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // Free-running clock.
    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // Builds the reading for the frame held so far and closes the capture.
    function automatic t_out frame_reading();
        t_out       rd;
        logic [7:0] sum;
        sum = frm[0] + frm[1] + frm[2] + frm[3];
        rd.humidity_tenths = {frm[0], frm[1]};
        rd.temperature_tenths = {1'b0, frm[2][6:0], frm[3]};
        if (frm[2][7]) begin
            rd.temperature_tenths = -rd.temperature_tenths;
        end
        rd.bits_received = bit_cnt;
        rd.checksum_ok = (frm[4] == sum);
        rd.frame_valid = (bit_cnt >= FRAME_BITS) && rd.checksum_ok;
        cap_on = 1'b0;
        return rd;
    endfunction

    // Advances the predicted decoder by one pin sample; returns 1 when a reading is due.
    function automatic logic decode_sample(input t_in smp, output t_out rd);
        logic [2:0] byte_sel;
        rd = '0;
        if (smp.start_req) begin
            cap_on = 1'b1;
            prev_lvl = 1'b1;
            run_cnt = '0;
            edge_cnt = '0;
            bit_cnt = '0;
            frm = '0;
        end
        if (!cap_on) begin
            return 1'b0;
        end

        // An unchanged level extends the current run and may time out the capture.
        if (smp.pin_level == prev_lvl) begin
            if (run_cnt != 8'd255) begin
                run_cnt = run_cnt + 8'd1;
            end
            if (run_cnt >= tmo_reg) begin
                rd = frame_reading();
                return 1'b1;
            end
            return 1'b0;
        end

        // A level change closes the run; even changes past the preamble carry a bit.
        prev_lvl = smp.pin_level;
        if (edge_cnt >= SKIP_EDGES && !edge_cnt[0]) begin
            if (bit_cnt < FRAME_BITS) begin
                byte_sel = bit_cnt[5:3];
                frm[byte_sel] = {frm[byte_sel][6:0], run_cnt > thr_reg};
            end
            if (bit_cnt < BIT_MAX) begin
                bit_cnt = bit_cnt + 6'd1;
            end
        end
        run_cnt = '0;
        edge_cnt = edge_cnt + 8'd1;
        if (edge_cnt >= EDGE_LIMIT) begin
            rd = frame_reading();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void add_cfg(input logic [CFG_INDEX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
        t_directed_row r;
        r = '0;
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.val = val;
        directed_steps.push_back(r);
    endfunction

    function automatic void add_sample(input logic start, input logic level,
                                       input logic typed = 1'b0, input t_out want = '0);
        t_directed_row r;
        r = '0;
        r.smp.start_req = start;
        r.smp.pin_level = level;
        r.typed = typed;
        r.want = want;
        directed_steps.push_back(r);
    endfunction

    function automatic void check_field(input string field, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endfunction

    // Offers one pin sample, waits for its transaction and records the predicted reading.
    // Called at a falling edge and returns at the next falling edge after acceptance.
    task automatic send_sample(input logic start, input logic level,
                               input logic typed = 1'b0, input t_out want = '0);
        t_in  smp;
        t_out rd;
        logic due;
        smp.start_req = start;
        smp.pin_level = level;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= smp;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        items_sent++;
        due = decode_sample(smp, rd);
        if (typed) begin
            pending_readings.push_back(want);
        end else if (due) begin
            pending_readings.push_back(rd);
        end
        @(negedge i_clk);
    endtask

    // Writes one register through the configuration channel.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            REG_BIT_THRESHOLD: thr_reg = val;
            REG_TIMEOUT_TICKS: tmo_reg = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Ends any open capture by timeout, then waits until every reading has come out.
    task automatic quiesce();
        while (cap_on) begin
            send_sample(1'b0, prev_lvl);
        end
        i_in_valid <= 1'b0;
        while (pending_readings.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Random samples with occasional restarts and level changes.
    task automatic send_noise(input int count);
        logic lvl;
        lvl = 1'($urandom_range(1));
        repeat (count) begin
            if ($urandom_range(99) < 30) begin
                lvl = ~lvl;
            end
            send_sample($urandom_range(99) < 6, lvl);
        end
    endtask

    // Drives a well-formed sensor response: start low, preamble, then one high run
    // per bit, long for a one. The last segment decides how the capture ends.
    task automatic send_frame(input logic [47:0] payload, input int nbits,
                              input t_frame_end ending);
        int last_seg;
        int len;
        int span;
        int thr;
        int tmo;
        thr = int'(thr_reg);
        tmo = int'(tmo_reg);
        span = tmo - thr - 2;
        if (span > 2) begin
            span = 2;
        end
        last_seg = (ending == END_AT_LIMIT) ? EDGE_LIMIT - 1 : 2 * nbits + 2;
        for (int seg = 0; seg <= last_seg; seg++) begin
            if (seg == last_seg && ending == END_AT_LIMIT) begin
                len = 1;
            end else if (seg == last_seg && ending == END_BY_TIMEOUT) begin
                len = tmo + 1;
            end else if (seg >= 3 && seg % 2 == 1) begin
                if (payload[47 - (seg - 3) / 2]) begin
                    len = thr + 2 + $urandom_range(0, span);
                end else begin
                    len = $urandom_range(1, thr + 1);
                end
            end else begin
                len = $urandom_range(1, 3);
            end
            for (int k = 0; k < len; k++) begin
                send_sample(seg == 0 && k == 0, seg % 2 == 1);
            end
        end
    endtask

    // Output side: accepts readings with random stalls and one long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_grants != holds_served) begin
            holds_served = holds_served + 1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Compares every output transaction with the oldest predicted reading.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            readings_seen++;
            if (pending_readings.size() == 0) begin
                $error("reading with none expected: humidity_tenths %0d bits_received %0d",
                       o_out_data.humidity_tenths, o_out_data.bits_received);
                mismatches++;
            end else begin
                want = pending_readings.pop_front();
                check_field("humidity_tenths", want.humidity_tenths,
                            o_out_data.humidity_tenths);
                check_field("temperature_tenths", want.temperature_tenths,
                            o_out_data.temperature_tenths);
                check_field("bits_received", want.bits_received, o_out_data.bits_received);
                check_field("checksum_ok", want.checksum_ok, o_out_data.checksum_ok);
                check_field("frame_valid", want.frame_valid, o_out_data.frame_valid);
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("single_wire_humidity_sensor_decoder_top regression: fail");
                $finish;
            end
        end
    end

    // Stimulus sequence.
    initial begin
        logic [FRAME_BYTES-1:0][7:0] fb;
        logic [47:0]                 payload;
        int                          kind;
        int                          phase_start;
        int                          p;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part: idle samples, zero timeout, restart and a two-bit frame.
        add_sample(1'b0, 1'b0);
        add_sample(1'b0, 1'b1);
        add_cfg(REG_TIMEOUT_TICKS, 8'd0);
        add_sample(1'b1, 1'b1, 1'b1, BLANK_READING);
        add_cfg(REG_TIMEOUT_TICKS, 8'd1);
        add_sample(1'b1, 1'b0);
        add_sample(1'b0, 1'b0, 1'b1, BLANK_READING);
        add_cfg(REG_TIMEOUT_TICKS, 8'd3);
        add_cfg(REG_BIT_THRESHOLD, 8'd0);
        add_sample(1'b1, 1'b0);
        add_sample(1'b0, 1'b1);
        add_sample(1'b1, 1'b1);
        add_sample(1'b0, 1'b0);
        add_sample(1'b0, 1'b1);
        add_sample(1'b0, 1'b0);
        add_sample(1'b0, 1'b1);
        add_sample(1'b0, 1'b1);
        add_sample(1'b0, 1'b0);
        add_sample(1'b0, 1'b1);
        add_sample(1'b0, 1'b0);
        add_sample(1'b0, 1'b0);
        add_sample(1'b0, 1'b0);
        add_sample(1'b0, 1'b0);
        add_cfg(REG_BIT_THRESHOLD, 8'd255);
        add_cfg(REG_TIMEOUT_TICKS, 8'd255);
        add_sample(1'b0, 1'b1);

        foreach (directed_steps[i]) begin
            if (directed_steps[i].is_cfg) begin
                quiesce();
                write_reg(directed_steps[i].idx, directed_steps[i].val);
            end else begin
                send_sample(directed_steps[i].smp.start_req, directed_steps[i].smp.pin_level,
                            directed_steps[i].typed, directed_steps[i].want);
            end
        end
        quiesce();

        // Random phases, each with its own register setting and idling pattern.
        for (p = 0; p < 8 || items_sent < ITEM_GOAL || readings_seen < READING_GOAL; p++) begin
            case (p % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 81; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 81; end
                default: begin tx_idle_pct = 38; rx_stall_pct = 38; end
            endcase
            write_reg(REG_BIT_THRESHOLD, PHASE_THR[p % 8]);
            write_reg(REG_TIMEOUT_TICKS, PHASE_TMO[p % 8]);

            // Hold the output off while short captures pile up behind it.
            if (p == 2) begin
                hold_grants++;
                repeat (8) begin
                    send_sample(1'b1, 1'b1);
                    repeat (tmo_reg - 1) send_sample(1'b0, 1'b1);
                end
            end

            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                kind = $urandom_range(9);
                fb = 40'({$urandom, $urandom});
                case ($urandom_range(4))
                    0: begin fb[2] = 8'h80; fb[3] = 8'h00; end
                    1: fb = '1;
                    2: fb = '0;
                    3: fb[2][7] = 1'b1;
                    default: ;
                endcase
                if ($urandom_range(3) != 0) begin
                    fb[4] = fb[0] + fb[1] + fb[2] + fb[3];
                end
                payload = {fb[0], fb[1], fb[2], fb[3], fb[4], 8'($urandom)};

                if (int'(tmo_reg) < int'(thr_reg) + 3 || kind >= 8) begin
                    send_noise($urandom_range(10, 40));
                end else if (kind <= 4) begin
                    send_frame(payload, $urandom_range(1) ? 40 + $urandom_range(7)
                                                          : $urandom_range(39),
                               END_BY_TIMEOUT);
                end else if (kind <= 6) begin
                    send_frame(payload, 48, END_AT_LIMIT);
                end else begin
                    send_frame(payload, $urandom_range(47), END_ABORTED);
                end
            end
            quiesce();
        end

        $display("Covered %0d decoder samples and %0d checked readings over %0d phases.",
                 items_sent, readings_seen, p);
        $display("Thresholds and timeouts swept 0 to 255, with stalls on both sides.");
        if (mismatches == 0) begin
            $display("single_wire_humidity_sensor_decoder_top regression: pass");
        end else begin
            $display("single_wire_humidity_sensor_decoder_top regression: fail");
        end
        $finish;
    end

endmodule

[single_wire_humidity_sensor_decoder_top.f]
hw/rtl/swhsd_pkg.sv
hw/rtl/swhsd_capture.sv
hw/rtl/swhsd_result.sv
hw/rtl/single_wire_humidity_sensor_decoder_top.sv
tb/single_wire_humidity_sensor_decoder_top_tb.sv
